/* hdl/pbm_pkg.sv */
// ============================================================================
// pbm_pkg: shared types and constants for the Pascal binomial block
// Field widths of the item words and the control bundle that drives the
// row of triangle cells.
// ============================================================================
`default_nettype none

package pbm_pkg;

    localparam int unsigned N_W = 10;   // width of n and r
    localparam int unsigned M_W = 31;   // width of modulus and coefficient

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;     // start of an item: seed edge and diagonal marks
        logic step;     // advance one row of the triangle
        logic m_one;    // modulus is one: every interior entry is zero
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hdl/pbm_if.sv */
// ============================================================================
// pbm_if: item channels of the Pascal binomial block
// Valid/ready channels for the request word (n, r, modulus) and the
// result word (coefficient, bad_modulus).
// ============================================================================
`default_nettype none

interface pbm_in_if;
    logic                      valid;
    logic                      ready;
    logic [pbm_pkg::N_W-1:0]   top_count;
    logic [pbm_pkg::N_W-1:0]   choose_count;
    logic [pbm_pkg::M_W-1:0]   modulus;

    modport source (output valid, output top_count, output choose_count,
                    output modulus, input ready);
    modport sink   (input valid, input top_count, input choose_count,
                    input modulus, output ready);
endinterface

interface pbm_out_if;
    logic                      valid;
    logic                      ready;
    logic [pbm_pkg::M_W-1:0]   coefficient;
    logic                      bad_modulus;

    modport source (output valid, output coefficient, output bad_modulus,
                    input ready);
    modport sink   (input valid, input coefficient, input bad_modulus,
                    output ready);
endinterface

`default_nettype wire

/* hdl/pbm_cell.sv */
// ============================================================================
// pbm_cell: one column of the Pascal triangle
// Holds one entry of the current row; each step adds the right-hand
// neighbour's entry modulo m and passes the diagonal mark leftwards.
// ============================================================================
`default_nettype none

module pbm_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire pbm_pkg::t_cell_ctl      i_ctl,
    input  wire logic [pbm_pkg::M_W-1:0] i_modulus,
    input  wire logic                    i_col_zero,
    input  wire logic                    i_tok_right,
    input  wire logic [pbm_pkg::M_W-1:0] i_val_right,
    output      logic                    o_tok,
    output      logic [pbm_pkg::M_W-1:0] o_val
);

    logic                    r_tok;
    logic                    r_live;
    logic                    r_zero;
    logic [pbm_pkg::M_W-1:0] r_val;
    logic [pbm_pkg::M_W-1:0] n_val;
    logic [pbm_pkg::M_W:0]   w_sum;

    // Both operands stay below m (m of two or more), so one subtract reduces.
    always_comb begin
        w_sum = {1'b0, r_val} + {1'b0, i_val_right};
        if (r_zero || r_tok) begin
            n_val = pbm_pkg::M_W'(1);
        end else if (!r_live) begin
            n_val = r_val;
        end else if (i_ctl.m_one) begin
            n_val = '0;
        end else if (w_sum >= {1'b0, i_modulus}) begin
            n_val = pbm_pkg::M_W'(w_sum - {1'b0, i_modulus});
        end else begin
            n_val = w_sum[pbm_pkg::M_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_live <= 1'b0;
            r_zero <= 1'b0;
        end else if (i_ctl.load) begin
            r_tok  <= i_col_zero;
            r_live <= 1'b0;
            r_zero <= i_col_zero;
        end else if (i_ctl.step) begin
            r_tok  <= i_tok_right;
            r_live <= r_live | r_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_val <= n_val;
        end
    end

    assign o_tok = r_tok;
    assign o_val = r_val;

endmodule

`default_nettype wire

/* hdl/pascal_binomial_mod.sv */
// ============================================================================
// pascal_binomial_mod: binomial coefficient C(n,r) mod m by Pascal rows
// Sequencer and a chain of MAX_N+1 triangle cells.
// ============================================================================
// Each request word carries n, r and a modulus m; the block answers with
// one result word holding C(n,r) mod m. Edge entries of the triangle are
// kept as 1, so r of 0 or r equal to n gives 1 even for a modulus of 1. A
// zero modulus sets bad_modulus and returns 0; r above n, or n above MAX_N,
// returns 0 with the flag clear. One request is worked at a time: for a
// valid request the cell chain steps through rows 0 to n, one row of the
// triangle per cycle, then cell 0 is captured and the result word is
// offered; for the trivial cases it is offered in the cycle straight after
// acceptance. The next request is taken once the result word has been
// handed over.
// ============================================================================
`default_nettype none

module pascal_binomial_mod #(
    parameter int unsigned MAX_N = 1023
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pbm_in_if.sink     i_in,
    pbm_out_if.source  o_out
);

    // Cell j holds column r - j of the current row, so the answer ends up
    // in cell 0 and the column-0 edge sits at cell r. The diagonal mark
    // starts at cell r and walks one cell left per row.
    localparam int unsigned IW   = (MAX_N < 1) ? 1 : $clog2(MAX_N + 1);
    localparam int unsigned CMPW = (IW > pbm_pkg::N_W) ? IW : pbm_pkg::N_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_TAKE,
        S_SEND
    } t_state;

    t_state                    r_state;
    logic [pbm_pkg::N_W-1:0]   r_row;
    logic [pbm_pkg::N_W-1:0]   r_n;
    logic [pbm_pkg::M_W-1:0]   r_m;
    logic                      r_m_one;
    logic [pbm_pkg::M_W-1:0]   r_coef;
    logic                      r_bad;

    logic                      w_accept;
    pbm_pkg::t_cell_ctl        w_ctl;
    logic                      w_tok [0:MAX_N+1];
    logic [pbm_pkg::M_W-1:0]   w_val [0:MAX_N+1];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_ctl.load  = w_accept;
    assign w_ctl.step  = (r_state == S_RUN);
    assign w_ctl.m_one = r_m_one;

    // Nothing lies beyond the last cell.
    assign w_tok[MAX_N+1] = 1'b0;
    assign w_val[MAX_N+1] = '0;

    for (genvar j = 0; j <= MAX_N; j++) begin : g_cell
        localparam logic [CMPW-1:0] IDX = CMPW'(j);
        logic w_col_zero;

        assign w_col_zero = (CMPW'(i_in.choose_count) == IDX);

        pbm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_modulus   (r_m),
            .i_col_zero  (w_col_zero),
            .i_tok_right (w_tok[j+1]),
            .i_val_right (w_val[j+1]),
            .o_tok       (w_tok[j]),
            .o_val       (w_val[j])
        );
    end

    // Sequencer: take a word, run rows 0..n, capture cell 0, offer result; trivial words go straight to the offer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n     <= i_in.top_count;
                        r_m     <= i_in.modulus;
                        r_m_one <= (i_in.modulus == pbm_pkg::M_W'(1));
                        r_row   <= '0;
                        if (i_in.modulus == '0) begin
                            r_coef  <= '0;
                            r_bad   <= 1'b1;
                            r_state <= S_SEND;
                        end else if ((32'(i_in.top_count) > 32'(MAX_N)) ||
                                     (i_in.choose_count > i_in.top_count)) begin
                            r_coef  <= '0;
                            r_bad   <= 1'b0;
                            r_state <= S_SEND;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    // advance one row per cycle; stop after row n
                    r_row <= r_row + 1'b1;
                    if (r_row == r_n) begin
                        r_state <= S_TAKE;
                    end
                end
                S_TAKE: begin
                    r_coef  <= w_val[0];
                    r_bad   <= 1'b0;
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    // hold the word until the sink takes it
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = (r_state == S_SEND);
    assign o_out.coefficient = r_coef;
    assign o_out.bad_modulus = r_bad;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for pascal_binomial_mod
// Drives request words (n, r, modulus) through the valid/ready channel,
// predicts C(n,r) mod m with an independent Pascal-row calculation and
// checks every result word in order, under random idling on both sides.
// ============================================================================

module tb;

    localparam int unsigned N_W = pbm_pkg::N_W;
    localparam int unsigned M_W = pbm_pkg::M_W;

    localparam logic [M_W-1:0] MOD_MAX   = '1;
    localparam logic [N_W-1:0] TOP_MAX   = '1;
    localparam int unsigned SETTLE_CYCLES = 8;          // idle time after the last result word
    localparam int unsigned HOLD_OFF_LEN  = 400;        // long receiver stall
    localparam int unsigned RUN_LIMIT_NS  = 20_000_000; // several times the slowest run

    // Result word as the predictor sees it.
    typedef struct packed {
        logic [M_W-1:0] coefficient;
        logic           bad_modulus;
    } t_binom_word;

    logic i_clk;
    logic i_rst_n;

    pbm_in_if  req_if ();
    pbm_out_if res_if ();

    pascal_binomial_mod u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Predicted result words, oldest first.
    t_binom_word awaited_coefficients[$];
    int          error_count   = 0;

    // Sender bookkeeping: whether valid is held high for a word not yet taken,
    // and how many idle cycles to leave before the next word.
    bit          offering      = 1'b0;
    int          next_gap      = 0;

    // Idling control: idle_on for both sides, the hold-off for the receiver.
    bit          idle_on       = 1'b1;
    int          hold_off_req  = 0;
    bit          holding_off   = 1'b0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: C(n,r) mod m built row by row. Only columns up to
    // min(r, n-r) are kept, using the symmetry of the triangle. Edge entries
    // stay at 1 unreduced, so a modulus of one still gives 1 on the edges
    // and 0 inside.
    // ------------------------------------------------------------------------
    function automatic t_binom_word pascal_residue(input bit [N_W-1:0] n,
                                                   input bit [N_W-1:0] r,
                                                   input bit [M_W-1:0] m);
        bit [M_W-1:0] row [0:TOP_MAX];
        bit [M_W:0]   pair_sum;
        t_binom_word  res;
        int           span;
        int           top;
        res = '0;
        if (m == '0) begin
            res.bad_modulus = 1'b1;
        end else if (r <= n) begin
            if (r == 0 || r == n) begin
                res.coefficient = M_W'(1);
            end else if (m == 1) begin
                res.coefficient = '0;
            end else begin
                span = (int'(r) < int'(n) - int'(r)) ? int'(r) : int'(n) - int'(r);
                row[0] = M_W'(1);
                for (int j = 1; j <= span; j++) row[j] = '0;
                for (int i = 1; i <= int'(n); i++) begin
                    top = (i < span) ? i : span;
                    // update from the high column down so the row can be reused
                    for (int j = top; j >= 1; j--) begin
                        pair_sum = {1'b0, row[j]} + {1'b0, row[j-1]};
                        row[j]   = M_W'(pair_sum % {1'b0, m});
                    end
                end
                res.coefficient = row[span];
            end
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_length();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(99);
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Raise valid with the word, hold it until taken, then predict.
    // Leave valid high when the next word follows at once, so valid gets a
    // single assignment per edge.
    // ------------------------------------------------------------------------
    task automatic send_request(input bit [N_W-1:0] n, input bit [N_W-1:0] r,
                                input bit [M_W-1:0] m);
        if (!offering) repeat (next_gap) @(posedge i_clk);
        req_if.valid        <= 1'b1;
        req_if.top_count    <= n;
        req_if.choose_count <= r;
        req_if.modulus      <= m;
        offering = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        awaited_coefficients.push_back(pascal_residue(n, r, m));
        next_gap = idle_length();
        if (next_gap > 0) begin
            req_if.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Drop valid after the last word of a burst.
    task automatic idle_input();
        if (offering) begin
            req_if.valid <= 1'b0;
            offering = 1'b0;
        end
        if (next_gap == 0) next_gap = 1;
    endtask

    // Wait for every outstanding result word, then let the block settle.
    task automatic drain_results();
        idle_input();
        while (awaited_coefficients.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random word: most n small to keep the run short, a few across the
    // whole range; r on the edges, inside, or beyond n; moduli of every kind.
    task automatic send_random_request();
        bit [N_W-1:0] n;
        bit [N_W-1:0] r;
        bit [M_W-1:0] m;
        int           roll;
        n = ($urandom_range(99) < 6) ? N_W'($urandom_range(TOP_MAX))
                                     : N_W'($urandom_range(63));
        roll = $urandom_range(99);
        if (roll < 8)
            r = '0;
        else if (roll < 16)
            r = n;
        else if (roll < 26 && n < TOP_MAX)
            r = N_W'($urandom_range(TOP_MAX, int'(n) + 1));
        else
            r = N_W'($urandom_range(int'(n)));
        roll = $urandom_range(99);
        if (roll < 5)
            m = '0;
        else if (roll < 15)
            m = M_W'(1);
        else if (roll < 40)
            m = M_W'($urandom_range(16, 2));
        else if (roll < 55)
            m = M_W'($urandom_range(1000, 17));
        else if (roll < 65)
            m = MOD_MAX;
        else
            m = M_W'($urandom());
        send_request(n, r, m);
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker. Compare each taken result word with the oldest
    // prediction, then pick ready for the next edge: low through a hold-off,
    // low through a random stall, high otherwise.
    // ------------------------------------------------------------------------
    initial begin : result_checker
        t_binom_word want;
        int          stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (awaited_coefficients.size() == 0) begin
                    $error("result word with none awaited: coefficient %0d, bad_modulus %0b",
                           res_if.coefficient, res_if.bad_modulus);
                    error_count++;
                end else begin
                    want = awaited_coefficients.pop_front();
                    if (res_if.coefficient !== want.coefficient) begin
                        $error("coefficient: expected %0d, actual %0d",
                               want.coefficient, res_if.coefficient);
                        error_count++;
                    end
                    if (res_if.bad_modulus !== want.bad_modulus) begin
                        $error("bad_modulus: expected %0b, actual %0b",
                               want.bad_modulus, res_if.bad_modulus);
                        error_count++;
                    end
                end
            end
            if (holding_off) begin
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = idle_length();
                if (stall_left > 0) begin
                    res_if.ready <= 1'b0;
                    stall_left--;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering.
    initial begin : receiver_hold_off
        forever begin
            wait (hold_off_req != 0);
            holding_off <= 1'b1;
            repeat (hold_off_req) @(posedge i_clk);
            holding_off <= 1'b0;
            hold_off_req = 0;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, each special case and a few exact values.
    task automatic test_edges_and_specials();
        // edges stay 1 and the interior 0 with a modulus of one
        send_request(0, 0, 1);
        send_request(TOP_MAX, 0, 1);
        send_request(TOP_MAX, TOP_MAX, 1);
        send_request(5, 2, 1);
        // r beyond n gives 0 with the flag clear
        send_request(10, 11, 7);
        send_request(0, TOP_MAX, MOD_MAX);
        send_request(TOP_MAX - 1'b1, TOP_MAX, 2);
        // zero modulus flags and returns 0 whatever n and r are
        send_request(0, 0, 0);
        send_request(7, 7, 0);
        send_request(7, 3, 0);
        send_request(3, 9, 0);
        send_request(TOP_MAX, TOP_MAX, 0);
        // known values, both below the largest modulus and reduced by a modulus
        send_request(30, 15, MOD_MAX);
        send_request(64, 32, MOD_MAX);
        send_request(1, 1, MOD_MAX);
        send_request(2, 1, 2);
        send_request(100, 50, 3);
        // largest row, and alternating bit patterns in every field
        send_request(TOP_MAX, TOP_MAX >> 1, MOD_MAX);
        send_request(TOP_MAX, 512, 2);
        send_request(10'h2AA, 10'h155, 31'h2AAA_AAAA);
        send_request(10'h155, 10'h0AA, 31'h5555_5555);
        send_request(TOP_MAX, TOP_MAX, MOD_MAX);
        drain_results();
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back();
        idle_on   = 1'b0;
        next_gap  = 0;
        repeat (40) send_random_request();
        drain_results();
        idle_on   = 1'b1;
    endtask

    // Hold the result channel off for a long stretch while words keep coming,
    // so the block fills and stalls its input.
    task automatic test_output_hold_off();
        hold_off_req = HOLD_OFF_LEN;
        repeat (8) send_request(N_W'($urandom_range(40)), N_W'($urandom_range(20)),
                                M_W'($urandom_range(1000, 2)));
        drain_results();
    endtask

    task automatic test_random_mix();
        repeat (380) send_random_request();
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.top_count    <= '0;
        req_if.choose_count <= '0;
        req_if.modulus      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edges_and_specials();
        test_back_to_back();
        test_output_hold_off();
        test_random_mix();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/pbm_pkg.sv
hdl/pbm_if.sv
hdl/pbm_cell.sv
hdl/pascal_binomial_mod.sv
test/tb.sv
